// File: hw/rtl/wpbc_pkg.sv
// ----------------------------------------------------------------------------
// wpbc_pkg
// shared types and constants for the window perimeter branch counter
// ----------------------------------------------------------------------------
package wpbc_pkg;

   // default largest window side
   localparam int unsigned MAX_WINDOW_SIDE_DEF = 1024;

   // field widths
   localparam int unsigned SIDE_IN_W = 11;
   localparam int unsigned MIN_RUN_W = 12;
   localparam int unsigned BRANCH_W  = 11;

   // smallest supported window side
   localparam int unsigned MIN_SIDE = 2;

   // min_run_length after reset
   localparam logic [MIN_RUN_W-1:0] MIN_RUN_RESET = 12'd15;

   // one perimeter pixel with the window size
   typedef struct packed {
      logic                 white;
      logic [SIDE_IN_W-1:0] win_width;
      logic [SIDE_IN_W-1:0] win_height;
   } req_type;

   // one per-window result
   typedef struct packed {
      logic [BRANCH_W-1:0] branch_count;
      logic                side_hit;
   } rsp_type;

endpackage

// File: hw/rtl/wpbc_ifs.sv
// ----------------------------------------------------------------------------
// wpbc channel interfaces
// valid/ready channels for perimeter pixels and per-window results
// ----------------------------------------------------------------------------
interface wpbc_req_if import wpbc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 white;
   logic [SIDE_IN_W-1:0] win_width;
   logic [SIDE_IN_W-1:0] win_height;

   modport source (output valid, white, win_width, win_height, input ready);
   modport sink   (input valid, white, win_width, win_height, output ready);
endinterface

interface wpbc_rsp_if import wpbc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [BRANCH_W-1:0] branch_count;
   logic                side_hit;

   modport source (output valid, branch_count, side_hit, input ready);
   modport sink   (input valid, branch_count, side_hit, output ready);
endinterface

// File: hw/rtl/wpbc_perim_core.sv
// ----------------------------------------------------------------------------
// wpbc_perim_core
// per-pixel run tracking and side counting, result on the last border pixel
// ----------------------------------------------------------------------------
module wpbc_perim_core import wpbc_pkg::*; #(
   parameter int unsigned MAX_WINDOW_SIDE = MAX_WINDOW_SIDE_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  req_type              pixel,
   input  logic [MIN_RUN_W-1:0] min_run,
   output logic                 is_last,
   output rsp_type              result
);

   localparam int unsigned SIDE_W = $clog2(MAX_WINDOW_SIDE + 1);
   localparam int unsigned POS_W  = $clog2(4 * MAX_WINDOW_SIDE);
   localparam int unsigned BND_W  = POS_W + 1;
   localparam int unsigned CMP_W  = (POS_W > MIN_RUN_W) ? POS_W : MIN_RUN_W;

   function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_IN_W-1:0] v);
      logic [CMP_W-1:0] vx;
      vx = CMP_W'(v);
      if (vx < CMP_W'(MIN_SIDE)) begin
         return SIDE_W'(MIN_SIDE);
      end else if (vx > CMP_W'(MAX_WINDOW_SIDE)) begin
         return SIDE_W'(MAX_WINDOW_SIDE);
      end else begin
         return SIDE_W'(v);
      end
   endfunction

   // window state
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  right_lo_ff, right_hi_ff, left_lo_ff, last_pos_ff;
   logic              colour_ff, colour_in;
   logic [POS_W-1:0]  len_ff, len_in;
   logic [POS_W-1:0]  kept_ff, kept_in;
   logic              first_kept_ff, first_kept_in;
   logic              last_kept_ff, last_kept_in;
   logic [SIDE_W-1:0] left_cnt_ff, left_cnt_in;
   logic [SIDE_W-1:0] right_cnt_ff, right_cnt_in;

   logic              first_pix;
   logic              pix;
   logic [SIDE_W-1:0] w_cl, h_cl;
   logic [BND_W-1:0]  wx, hx;
   logic [BND_W-1:0]  right_lo_new, right_hi_new, left_lo_new, last_pos_new;
   logic              in_left, in_right;
   logic              run_break, keep_old, keep_tail;
   logic [POS_W-1:0]  len_step, kept_step, count, count_adj;
   logic              first_step, last_step, first_fin, last_fin;

   assign pix       = pixel.white;
   assign first_pix = (pos_ff == '0);

   // border boundaries from the clamped window size
   always_comb begin
      w_cl         = clamp_side(pixel.win_width);
      h_cl         = clamp_side(pixel.win_height);
      wx           = BND_W'(w_cl);
      hx           = BND_W'(h_cl);
      right_lo_new = wx - BND_W'(1);
      right_hi_new = wx + hx - BND_W'(2);
      left_lo_new  = (wx << 1) + hx - BND_W'(3);
      last_pos_new = (wx << 1) + (hx << 1) - BND_W'(5);
   end

   // the first pixel is never the last one
   assign is_last  = !first_pix && (pos_ff == last_pos_ff);
   assign in_right = !first_pix && (pos_ff >= right_lo_ff) && (pos_ff <= right_hi_ff);
   assign in_left  = first_pix || (pos_ff >= left_lo_ff);

   always_comb begin
      // side column counts
      left_cnt_in  = (first_pix ? '0 : left_cnt_ff) + SIDE_W'(pix & in_left);
      right_cnt_in = (first_pix ? '0 : right_cnt_ff) + SIDE_W'(pix & in_right);

      // run that ends at a colour change
      run_break  = !first_pix && (pix != colour_ff);
      keep_old   = run_break && (CMP_W'(len_ff) >= CMP_W'(min_run));
      len_step   = (first_pix || run_break) ? POS_W'(1) : len_ff + POS_W'(1);
      kept_step  = kept_ff + POS_W'(keep_old);
      first_step = (keep_old && kept_ff == '0) ? colour_ff : first_kept_ff;
      last_step  = keep_old ? colour_ff : last_kept_ff;

      // closing the open run at the end of the border
      keep_tail  = CMP_W'(len_step) >= CMP_W'(min_run);
      count      = kept_step + POS_W'(keep_tail);
      first_fin  = (keep_tail && kept_step == '0) ? pix : first_step;
      last_fin   = keep_tail ? pix : last_step;
      count_adj  = (count > POS_W'(1) && first_fin == last_fin) ? count - POS_W'(1) : count;

      result.branch_count = BRANCH_W'(count_adj >> 1);
      result.side_hit     = (CMP_W'(left_cnt_in) >= CMP_W'(min_run)) ||
                            (CMP_W'(right_cnt_in) >= CMP_W'(min_run));

      // next state, cleared after the last pixel
      if (is_last) begin
         pos_in        = '0;
         colour_in     = 1'b0;
         len_in        = '0;
         kept_in       = '0;
         first_kept_in = 1'b0;
         last_kept_in  = 1'b0;
         left_cnt_in   = '0;
         right_cnt_in  = '0;
      end else begin
         pos_in        = pos_ff + POS_W'(1);
         colour_in     = pix;
         len_in        = len_step;
         kept_in       = kept_step;
         first_kept_in = first_step;
         last_kept_in  = last_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         colour_ff     <= 1'b0;
         len_ff        <= '0;
         kept_ff       <= '0;
         first_kept_ff <= 1'b0;
         last_kept_ff  <= 1'b0;
         left_cnt_ff   <= '0;
         right_cnt_ff  <= '0;
      end else if (step) begin
         pos_ff        <= pos_in;
         colour_ff     <= colour_in;
         len_ff        <= len_in;
         kept_ff       <= kept_in;
         first_kept_ff <= first_kept_in;
         last_kept_ff  <= last_kept_in;
         left_cnt_ff   <= left_cnt_in;
         right_cnt_ff  <= right_cnt_in;
      end
   end

   // boundaries latched with the first pixel
   always_ff @(posedge clock) begin
      if (step && first_pix) begin
         right_lo_ff <= right_lo_new[POS_W-1:0];
         right_hi_ff <= right_hi_new[POS_W-1:0];
         left_lo_ff  <= left_lo_new[POS_W-1:0];
         last_pos_ff <= last_pos_new[POS_W-1:0];
      end
   end

endmodule

// File: hw/rtl/window_perimeter_branch_counter.sv
// ----------------------------------------------------------------------------
// window_perimeter_branch_counter
// counts branches crossing the border of a binary window
// ----------------------------------------------------------------------------
// Feed the border pixels of one window in perimeter order (top row left to
// right, right column down, bottom row right to left, left column up), one
// transfer per pixel, 2W+2H-4 transfers per window; the window size is taken
// from the first pixel and clamped to [2, MAX_WINDOW_SIDE]. One result comes
// out after the last pixel of each window and nothing for the others. The
// block takes one pixel per cycle unless a waiting result stalls it: each
// pixel is held in an input register, then a single pass of compare and
// counter logic updates the run state, and the result of the last pixel goes
// into an output register. A waiting result stalls input only when the
// pixel held in the input register is the last one of the next window.
// min_run_length is written through csr_wr_en / csr_wr_data; the user must
// write it only while no window is in progress; the block does not check.
// ----------------------------------------------------------------------------
module window_perimeter_branch_counter import wpbc_pkg::*; #(
   parameter int unsigned MAX_WINDOW_SIDE = MAX_WINDOW_SIDE_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   wpbc_req_if.sink             req_chan,
   wpbc_rsp_if.source           rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [MIN_RUN_W-1:0] csr_wr_data
);

   // configuration
   logic [MIN_RUN_W-1:0] min_run_ff;

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;

   // output register
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;

   logic    core_last;
   rsp_type core_result;
   logic    out_free;
   logic    core_step;
   logic    req_xfer;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_run_ff <= MIN_RUN_RESET;
      end else if (csr_wr_en) begin
         min_run_ff <= csr_wr_data;
      end
   end

   // output slot is free when empty or draining this cycle
   assign out_free  = !out_valid_ff || rsp_chan.ready;
   // a pixel that yields no result never waits on the output side
   assign core_step = in_valid_ff && (!core_last || out_free);
   assign req_chan.ready = !in_valid_ff || core_step;
   assign req_xfer  = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (core_step) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (core_step && core_last) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_data_ff.white      <= req_chan.white;
         in_data_ff.win_width  <= req_chan.win_width;
         in_data_ff.win_height <= req_chan.win_height;
      end
      if (core_step && core_last) begin
         out_data_ff <= core_result;
      end
   end

   // run tracking and side counts
   wpbc_perim_core #(
      .MAX_WINDOW_SIDE (MAX_WINDOW_SIDE)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (core_step),
      .pixel   (in_data_ff),
      .min_run (min_run_ff),
      .is_last (core_last),
      .result  (core_result)
   );

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.branch_count = out_data_ff.branch_count;
   assign rsp_chan.side_hit     = out_data_ff.side_hit;

endmodule

// File: hw/rtl/wpbc_checker.sv
// ----------------------------------------------------------------------------
// wpbc_checker
// port level checks for the window perimeter branch counter
// ----------------------------------------------------------------------------
module wpbc_checker import wpbc_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [BRANCH_W-1:0] rsp_branch_count,
   input logic                rsp_side_hit
);

   // reset empties both registers
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("wpbc: not empty after reset");

   // with the output side free, input is never stalled
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("wpbc: input stalled while output free");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_branch_count) && $stable(rsp_side_hit)))
      else $error("wpbc: stalled result changed");

endmodule

bind window_perimeter_branch_counter wpbc_checker u_wpbc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_branch_count (rsp_chan.branch_count),
   .rsp_side_hit     (rsp_chan.side_hit)
);

// File: tb/tb_window_perimeter_branch_counter.sv
// ----------------------------------------------------------------------------
// tb_window_perimeter_branch_counter
// Self-checking bench for the window perimeter branch counter. Border pixels
// go in as whole windows over the request channel. A cycle-free predictor
// tracks runs, side-column whites and the wrap merge for every accepted pixel
// and queues the expected per-window result, which the response checker
// compares field by field. Directed windows cover thresholds, wrap merge and
// size clamping; random windows follow under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_window_perimeter_branch_counter;
   import wpbc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // cycles of silence on both channels before the run is declared hung
   localparam int STALL_LIMIT   = 20000;
   // cycles the block may still be busy after the last result shows up
   localparam int RESULT_SETTLE = 8;

   // how the pixels of one border are generated
   typedef enum int {
      BORDER_FIXED,
      BORDER_NOISE,
      BORDER_RUNS,
      BORDER_EDGE_RUNS,
      BORDER_SOLID_WHITE,
      BORDER_SOLID_BLACK
   } border_style_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [MIN_RUN_W-1:0] csr_wr_data;

   wpbc_req_if req_if ();
   wpbc_rsp_if rsp_if ();

   window_perimeter_branch_counter u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // ------------------------------------------------------------------------
   // clock, 8 ns period
   // ------------------------------------------------------------------------
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // ------------------------------------------------------------------------
   // predictor state: mirrors the per-window counters of the block
   // ------------------------------------------------------------------------
   logic [MIN_RUN_W-1:0] min_run = MIN_RUN_RESET;
   logic [11:0]          perim_pos;
   logic [SIDE_IN_W-1:0] side_w;
   logic [SIDE_IN_W-1:0] side_h;
   logic                 run_white;
   logic [11:0]          run_len;
   logic [11:0]          runs_kept;
   logic                 first_white;
   logic                 last_white;
   logic [SIDE_IN_W-1:0] left_whites;
   logic [SIDE_IN_W-1:0] right_whites;

   // expected per-window results, oldest first
   rsp_type pending_windows[$];

   // traffic shaping knobs, the last two shared with the receiver process
   int tx_idle_pct   = 0;
   int rx_idle_pct   = 0;
   int rsp_hold_left = 0;

   int mismatches  = 0;
   int pixels_sent = 0;
   int idle_cycles = 0;

   function automatic void clear_window();
      perim_pos    = '0;
      side_w       = '0;
      side_h       = '0;
      run_white    = 1'b0;
      run_len      = '0;
      runs_kept    = '0;
      first_white  = 1'b0;
      last_white   = 1'b0;
      left_whites  = '0;
      right_whites = '0;
   endfunction

   // sizes below 2 or above the largest side are pulled into range
   function automatic logic [SIDE_IN_W-1:0] clamp_side(input logic [SIDE_IN_W-1:0] side);
      if (side < MIN_SIDE)
         return SIDE_IN_W'(MIN_SIDE);
      if (side > MAX_WINDOW_SIDE_DEF)
         return SIDE_IN_W'(MAX_WINDOW_SIDE_DEF);
      return side;
   endfunction

   // a finished run counts only if it is long enough
   function automatic void close_run();
      if (run_len >= min_run) begin
         if (runs_kept == 0)
            first_white = run_white;
         last_white = run_white;
         runs_kept++;
      end
   endfunction

   // advance the predictor by one accepted pixel
   task automatic track_perimeter_pixel(input req_type px);
      int          w;
      int          h;
      int          p;
      int          last_pos;
      logic [11:0] runs;
      rsp_type     res;
      p = perim_pos;
      // window size is taken from the first pixel only
      if (p == 0) begin
         side_w = clamp_side(px.win_width);
         side_h = clamp_side(px.win_height);
      end
      w        = side_w;
      h        = side_h;
      last_pos = 2 * w + 2 * h - 5;

      // right column runs from the top-right corner down to the bottom-right
      if (p >= w - 1 && p <= w + h - 2)
         right_whites += px.white;
      // left column: top-left corner plus bottom-left corner and up
      if (p == 0 || p >= 2 * w + h - 3)
         left_whites += px.white;

      if (p == 0) begin
         run_white = px.white;
         run_len   = 1;
      end else if (px.white == run_white) begin
         run_len++;
      end else begin
         close_run();
         run_white = px.white;
         run_len   = 1;
      end

      if (p < last_pos) begin
         perim_pos = p + 1;
      end else begin
         close_run();
         runs = runs_kept;
         // border wraps: first and last run of equal colour are one run
         if (runs > 1 && first_white == last_white)
            runs--;
         res.branch_count = runs[11:1];
         res.side_hit     = (left_whites >= min_run) || (right_whites >= min_run);
         pending_windows.insert(pending_windows.size(), res);
         clear_window();
      end
   endtask

   // ------------------------------------------------------------------------
   // request side: one pixel transfer, with random idle cycles before it
   // ------------------------------------------------------------------------
   task automatic send_pixel(input req_type px);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.white      <= px.white;
      req_if.win_width  <= px.win_width;
      req_if.win_height <= px.win_height;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      // transfer took place at this edge
      track_perimeter_pixel(px);
      pixels_sent++;
   endtask

   // one whole border; size fields of later pixels are don't-care, so random
   task automatic send_window(input logic [SIDE_IN_W-1:0] w_field,
                              input logic [SIDE_IN_W-1:0] h_field,
                              input border_style_type     style,
                              input logic [63:0]          fixed_bits);
      int      n;
      int      run_left;
      logic    colour;
      req_type px;
      n        = 2 * int'(clamp_side(w_field)) + 2 * int'(clamp_side(h_field)) - 4;
      colour   = 1'($urandom_range(1));
      run_left = 0;
      for (int i = 0; i < n; i++) begin
         px.win_width  = SIDE_IN_W'($urandom);
         px.win_height = SIDE_IN_W'($urandom);
         if (i == 0) begin
            px.win_width  = w_field;
            px.win_height = h_field;
         end
         case (style)
            BORDER_FIXED:       px.white = fixed_bits[i % 64];
            BORDER_NOISE:       px.white = 1'($urandom_range(1));
            BORDER_SOLID_WHITE: px.white = 1'b1;
            BORDER_SOLID_BLACK: px.white = 1'b0;
            default: begin
               // alternating runs; edge runs lie within one of the threshold
               if (run_left == 0) begin
                  colour = ~colour;
                  if (style == BORDER_EDGE_RUNS)
                     run_left = int'(min_run) + int'($urandom_range(2)) - 1;
                  else
                     run_left = int'($urandom_range(2 * int'(min_run) + 2, 1));
                  if (run_left < 1)
                     run_left = 1;
               end
               px.white = colour;
               run_left--;
            end
         endcase
         send_pixel(px);
      end
   endtask

   // drop valid, wait for every expected result, then let the block settle
   task automatic finish_phase();
      req_if.valid <= 1'b0;
      while (pending_windows.size() != 0)
         @(posedge clock);
      repeat (RESULT_SETTLE) @(posedge clock);
   endtask

   // register write, only ever with the block idle
   task automatic write_min_run(input logic [MIN_RUN_W-1:0] value);
      finish_phase();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      min_run = value;
   endtask

   // ------------------------------------------------------------------------
   // response side: random ready, plus a long hold-off on request
   // ------------------------------------------------------------------------
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // every result transfer is matched against the oldest expectation
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_windows.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual %0d %0d",
                     $time, rsp_if.branch_count, rsp_if.side_hit);
         end else begin
            want = pending_windows.pop_front();
            if (rsp_if.branch_count !== want.branch_count) begin
               mismatches++;
               $display("%0t: branch_count expected %0d actual %0d",
                        $time, want.branch_count, rsp_if.branch_count);
            end
            if (rsp_if.side_hit !== want.side_hit) begin
               mismatches++;
               $display("%0t: side_hit expected %0d actual %0d",
                        $time, want.side_hit, rsp_if.side_hit);
            end
         end
      end
   end

   // hang detection: cycles with no transfer on either channel
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // threshold straight out of reset: short borders keep no run at all
   task automatic test_reset_threshold();
      send_window(11'd2, 11'd2, BORDER_FIXED, 64'b0101);
      send_window(11'd3, 11'd3, BORDER_SOLID_WHITE, '0);
   endtask

   // every run kept; first/last colour decides whether the wrap merges
   task automatic test_wrap_merge();
      write_min_run(12'd1);
      send_window(11'd2, 11'd2, BORDER_FIXED, 64'b0101);   // four runs, no merge
      send_window(11'd2, 11'd2, BORDER_FIXED, 64'b1001);   // white at both ends
      send_window(11'd2, 11'd2, BORDER_FIXED, 64'b0110);   // black at both ends
      send_window(11'd2, 11'd2, BORDER_FIXED, 64'b1111);   // single run
   endtask

   // zero threshold keeps every run and always reports a side hit
   task automatic test_zero_threshold();
      write_min_run(12'd0);
      send_window(11'd2, 11'd2, BORDER_FIXED, 64'b0000);
   endtask

   // register extremes, side count right at the threshold, size clamping
   task automatic test_threshold_extremes();
      write_min_run(12'd4095);
      send_window(11'd3, 11'd3, BORDER_SOLID_WHITE, '0);
      send_window(11'd0, 11'd1, BORDER_NOISE, '0);           // clamps up to 2x2
      write_min_run(12'd4092);
      send_window(11'd3, 11'd3, BORDER_SOLID_WHITE, '0);     // three below the top of the register range
      write_min_run(12'd20);
      send_window(11'd2, 11'd20, BORDER_SOLID_WHITE, '0);    // side count equals threshold
      write_min_run(12'd21);
      send_window(11'd2, 11'd20, BORDER_SOLID_WHITE, '0);    // one short of it
   endtask

   // receiver holds off long enough for the block to stall its input
   task automatic test_receiver_backpressure();
      write_min_run(12'd2);
      tx_idle_pct   = 0;
      rx_idle_pct   = 0;
      rsp_hold_left = 500;
      for (int k = 0; k < 30; k++)
         send_window(11'd3, 11'd3, BORDER_NOISE, '0);
   endtask

   // random windows, mostly small, with the threshold changed every few windows
   task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int target);
      int                   start;
      int                   windows;
      logic [SIDE_IN_W-1:0] w_field;
      logic [SIDE_IN_W-1:0] h_field;
      logic [SIDE_IN_W-1:0] big;
      logic [SIDE_IN_W-1:0] tiny;
      logic [MIN_RUN_W-1:0] thresh;
      border_style_type     style;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      start       = pixels_sent;
      windows     = 0;
      while (pixels_sent - start < target) begin
         // sender pauses here until every result is in, then retunes
         if (windows % 8 == 0) begin
            case ($urandom_range(9))
               0:       thresh = 12'd0;
               1:       thresh = 12'd1;
               8:       thresh = MIN_RUN_W'($urandom_range(20, 7));
               9:       thresh = MIN_RUN_W'($urandom_range(4095));
               default: thresh = MIN_RUN_W'($urandom_range(6, 2));
            endcase
            write_min_run(thresh);
         end
         if ($urandom_range(39) == 0) begin
            // occasional long, thin window from a raw size field
            big  = SIDE_IN_W'($urandom_range(40));
            tiny = SIDE_IN_W'($urandom_range(3));
            if ($urandom_range(1)) begin
               w_field = big;
               h_field = tiny;
            end else begin
               w_field = tiny;
               h_field = big;
            end
         end else begin
            w_field = SIDE_IN_W'($urandom_range(8, 2));
            h_field = SIDE_IN_W'($urandom_range(8, 2));
         end
         case ($urandom_range(5))
            0:       style = BORDER_NOISE;
            1, 2:    style = BORDER_RUNS;
            3, 4:    style = BORDER_EDGE_RUNS;
            default: style = $urandom_range(1) ? BORDER_SOLID_WHITE : BORDER_SOLID_BLACK;
         endcase
         send_window(w_field, h_field, style, '0);
         windows++;
      end
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      req_if.valid      <= 1'b0;
      req_if.white      <= 1'b0;
      req_if.win_width  <= '0;
      req_if.win_height <= '0;
      clear_window();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_threshold();
      test_wrap_merge();
      test_zero_threshold();
      test_threshold_extremes();
      test_receiver_backpressure();
      test_random_traffic(19, 74, 240);
      test_random_traffic(74, 19, 240);
      test_random_traffic(0, 0, 240);
      finish_phase();

      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
